### hdl/blk3_pkg.sv
// ---------------------------------------------------------------------------
// BLAKE3 chunk compressor package
// Shared types, constants and helper functions for the chunk compressor.
// ---------------------------------------------------------------------------
`default_nettype none

package blk3_pkg;

  localparam int CV_WORDS    = 8;
  localparam int MSG_WORDS   = 16;
  localparam int ROUNDS      = 7;
  localparam int BLOCK_BYTES = 64;

  typedef logic [31:0] word_t;
  typedef logic [6:0]  fill_t;

  localparam logic [7:0] FLAG_START      = 8'h01;
  localparam logic [7:0] FLAG_END        = 8'h02;
  localparam logic [7:0] FLAG_INNER_NODE = 8'h04;
  localparam logic [7:0] FLAG_ROOT       = 8'h08;

  localparam word_t IV [CV_WORDS] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [3:0] PERM [MSG_WORDS] = '{
    4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
    4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
  };

  // Parameters of one compression besides the chaining value and message.
  typedef struct packed {
    logic [63:0] counter;
    fill_t       len;
    logic [7:0]  flags;
  } job_t;

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

`default_nettype wire

### hdl/blake3_chunk_compress.sv
// ---------------------------------------------------------------------------
// BLAKE3 chunk compressor
// Packs a word stream into 64-byte blocks, chains compressions from the IV
// and sends the final 8-word chaining value.
//
//   Channel  Handshake             Contents
//   in       in_valid / in_ready   data_word, word_bytes, first_word,
//                                  last_word, block_counter, domain_flags
//   out      out_valid / out_ready hash_word, hash_index, hash_last
//
// A word that does not close a block is registered in S_IDLE and placed in S_PLACE.
// Each compression runs 112 half-G steps on the shared mixer,
// plus load and finalization; a word that follows a full block pays one.
// A last word pays one more compression, then 8 output words, one per cycle
// while out_ready is high; in_ready stays low until the last one is taken.
// Reset loads the IV as chaining value and clears buffer, fill and flags.
// ---------------------------------------------------------------------------
`default_nettype none

module blake3_chunk_compress (
  input  var logic        clk,
  input  var logic        rst,
  input  var logic        in_valid,
  output logic            in_ready,
  input  var logic [31:0] data_word,
  input  var logic [2:0]  word_bytes,
  input  var logic        first_word,
  input  var logic        last_word,
  input  var logic [63:0] block_counter,
  input  var logic [7:0]  domain_flags,
  output logic            out_valid,
  input  var logic        out_ready,
  output logic [31:0]     hash_word,
  output logic [2:0]      hash_index,
  output logic            hash_last
);
  import blk3_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_PLACE    = 6'b000010,
    S_FLUSH    = 6'b000100,
    S_FINAL_GO = 6'b001000,
    S_FINAL    = 6'b010000,
    S_OUT      = 6'b100000
  } state_t;

  state_t      state;
  word_t       cv      [CV_WORDS];
  word_t       blk_buf [MSG_WORDS];
  fill_t       fill;
  logic        pending;
  logic [63:0] held_counter;
  logic [7:0]  held_flags;
  word_t       word_q;
  logic [2:0]  nb_q;
  logic        last_q;
  logic [2:0]  out_cnt;
  logic [2:0]  nb_in;
  word_t       word_in;
  logic        cmp_start;
  logic        cmp_done;
  logic        last_blk;
  job_t        job;
  word_t       cmp_cv  [CV_WORDS];

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign hash_word  = cv[out_cnt];
  assign hash_index = out_cnt;
  assign hash_last  = (out_cnt == 3'd7);

  always_comb begin
    nb_in = (last_word && word_bytes <= 3'd4) ? word_bytes : 3'd4;
    unique case (nb_in)
      3'd1:    word_in = {24'd0, data_word[7:0]};
      3'd2:    word_in = {16'd0, data_word[15:0]};
      3'd3:    word_in = {8'd0, data_word[23:0]};
      default: word_in = data_word;
    endcase
  end

  always_comb begin
    last_blk  = (state == S_FINAL_GO);
    cmp_start = last_blk || (state == S_PLACE && nb_q != 3'd0 && fill[6]);
    job.counter = held_counter;
    job.len     = last_blk ? fill : fill_t'(BLOCK_BYTES);
    job.flags   = held_flags;
    if (!last_blk) begin
      job.flags = job.flags & ~FLAG_ROOT;
    end
    if ((held_flags & FLAG_INNER_NODE) == 8'd0) begin
      if (pending) begin
        job.flags = job.flags | FLAG_START;
      end
      if (last_blk) begin
        job.flags = job.flags | FLAG_END;
      end
    end
  end

  blk3_compress u_compress (
    .clk    (clk),
    .rst    (rst),
    .start  (cmp_start),
    .job    (job),
    .cv_in  (cv),
    .msg_in (blk_buf),
    .done   (cmp_done),
    .cv_out (cmp_cv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cv           <= IV;
      blk_buf      <= '{default: '0};
      fill         <= '0;
      pending      <= 1'b1;
      held_counter <= '0;
      held_flags   <= '0;
      out_cnt      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            word_q <= word_in;
            nb_q   <= nb_in;
            last_q <= last_word;
            if (first_word) begin
              cv           <= IV;
              blk_buf      <= '{default: '0};
              fill         <= '0;
              pending      <= 1'b1;
              held_counter <= block_counter;
              held_flags   <= domain_flags;
            end
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (nb_q != 3'd0 && fill[6]) begin
            state <= S_FLUSH;
          end else begin
            if (nb_q != 3'd0) begin
              blk_buf[fill[5:2]] <= word_q;
              fill <= fill + fill_t'(nb_q);
            end
            state <= last_q ? S_FINAL_GO : S_IDLE;
          end
        end
        S_FLUSH: begin
          if (cmp_done) begin
            cv      <= cmp_cv;
            pending <= 1'b0;
            blk_buf <= '{default: '0};
            fill    <= '0;
            state   <= S_PLACE;
          end
        end
        S_FINAL_GO: begin
          state <= S_FINAL;
        end
        S_FINAL: begin
          if (cmp_done) begin
            cv      <= cmp_cv;
            pending <= 1'b0;
            out_cnt <= '0;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_cnt <= out_cnt + 3'd1;
            if (out_cnt == 3'd7) begin
              cv      <= IV;
              blk_buf <= '{default: '0};
              fill    <= '0;
              pending <= 1'b1;
              state   <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= fill_t'(BLOCK_BYTES))
    else $error("block fill beyond one block");

  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    cmp_done |-> (state == S_FLUSH || state == S_FINAL))
    else $error("compression finished with nobody waiting");

endmodule

`default_nettype wire

### hdl/blk3_gmix.sv
// ---------------------------------------------------------------------------
// BLAKE3 half mixing step
// One half of the G function: three additions, two xors and two rotations.
// ---------------------------------------------------------------------------
`default_nettype none

module blk3_gmix (
  input  var blk3_pkg::word_t a,
  input  var blk3_pkg::word_t b,
  input  var blk3_pkg::word_t c,
  input  var blk3_pkg::word_t d,
  input  var blk3_pkg::word_t x,
  input  var logic            half,
  output blk3_pkg::word_t     a_out,
  output blk3_pkg::word_t     b_out,
  output blk3_pkg::word_t     c_out,
  output blk3_pkg::word_t     d_out
);
  import blk3_pkg::*;

  word_t a1;
  word_t dx;
  word_t cx;

  always_comb begin
    a1    = a + b + x;
    dx    = d ^ a1;
    d_out = half ? rotr(dx, 8) : rotr(dx, 16);
    c_out = c + d_out;
    cx    = b ^ c_out;
    b_out = half ? rotr(cx, 7) : rotr(cx, 12);
    a_out = a1;
  end

endmodule

`default_nettype wire

### hdl/blk3_compress.sv
// ---------------------------------------------------------------------------
// BLAKE3 compression sequencer
// Runs seven rounds through one shared half-G unit.
// ---------------------------------------------------------------------------
`default_nettype none

module blk3_compress (
  input  var logic            clk,
  input  var logic            rst,
  input  var logic            start,
  input  var blk3_pkg::job_t  job,
  input  var blk3_pkg::word_t cv_in  [blk3_pkg::CV_WORDS],
  input  var blk3_pkg::word_t msg_in [blk3_pkg::MSG_WORDS],
  output logic                done,
  output blk3_pkg::word_t     cv_out [blk3_pkg::CV_WORDS]
);
  import blk3_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_RUN   = 3'b010,
    C_FINAL = 3'b100
  } cstate_t;

  cstate_t     state;
  logic [2:0]  round;
  logic [2:0]  gidx;
  logic        half;
  word_t       row  [4][4];
  word_t       msg  [MSG_WORDS];
  word_t       gout [4];
  word_t       rot  [4][4];
  word_t       dg   [4][4];
  word_t       msh  [MSG_WORDS];
  word_t       mperm [MSG_WORDS];
  logic        last_step;

  blk3_gmix u_gmix (
    .a     (row[0][0]),
    .b     (row[1][0]),
    .c     (row[2][0]),
    .d     (row[3][0]),
    .x     (half ? msg[1] : msg[0]),
    .half  (half),
    .a_out (gout[0]),
    .b_out (gout[1]),
    .c_out (gout[2]),
    .d_out (gout[3])
  );

  assign last_step = (state == C_RUN) && half && (gidx == 3'd7) && (round == 3'(ROUNDS - 1));

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        rot[k][j] = row[k][j + 1];
      end
      rot[k][3] = gout[k];
    end
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        if (gidx == 3'd3) begin
          dg[k][j] = rot[k][2'(j + k)];
        end else if (gidx == 3'd7) begin
          dg[k][j] = rot[k][2'(j + 4 - k)];
        end else begin
          dg[k][j] = rot[k][j];
        end
      end
    end
    for (int j = 0; j < MSG_WORDS; j++) begin
      msh[j] = msg[4'(j + 2)];
    end
    for (int j = 0; j < MSG_WORDS; j++) begin
      mperm[j] = msh[PERM[j]];
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= C_IDLE;
      round <= '0;
      gidx  <= '0;
      half  <= 1'b0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (start) begin
            for (int j = 0; j < 4; j++) begin
              row[0][j] <= cv_in[j];
              row[1][j] <= cv_in[j + 4];
              row[2][j] <= IV[j];
            end
            row[3][0] <= job.counter[31:0];
            row[3][1] <= job.counter[63:32];
            row[3][2] <= {25'd0, job.len};
            row[3][3] <= {24'd0, job.flags};
            msg   <= msg_in;
            round <= '0;
            gidx  <= '0;
            half  <= 1'b0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          if (!half) begin
            for (int k = 0; k < 4; k++) begin
              row[k][0] <= gout[k];
            end
            half <= 1'b1;
          end else begin
            row  <= dg;
            msg  <= (gidx == 3'd7) ? mperm : msh;
            half <= 1'b0;
            gidx <= gidx + 3'd1;
            if (gidx == 3'd7) begin
              round <= round + 3'd1;
            end
            if (last_step) begin
              state <= C_FINAL;
            end
          end
        end
        C_FINAL: begin
          for (int j = 0; j < 4; j++) begin
            cv_out[j]     <= row[0][j] ^ row[2][j];
            cv_out[j + 4] <= row[1][j] ^ row[3][j];
          end
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == C_IDLE)
    else $error("compression started while busy");

  a_done_final: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == C_FINAL))
    else $error("done without a final cycle");

  a_last_step: assert property (@(posedge clk) disable iff (rst)
    last_step |=> state == C_FINAL)
    else $error("round sequence did not finish");

endmodule

`default_nettype wire
